@@ rtl/audio_effect_chain_core_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the audio effect chain
// Shared property forms, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef AUDIO_EFFECT_CHAIN_CORE_DEFINES_SVH
`define AUDIO_EFFECT_CHAIN_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AEC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define AEC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/aec_pkg.sv @@
// ----------------------------------------------------------------------------
// Audio effect chain package
// Sizes, register codes and constants shared by the chain's modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package aec_pkg;

  localparam int SAMPLE_W  = 8;
  localparam int ENABLES_W = 6;
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 3;

  localparam int PITCH_DEPTH  = 256;
  localparam int ECHO_DEPTH   = 1024;
  localparam int FLANGE_DEPTH = 256;

  localparam int PAW = $clog2(PITCH_DEPTH);
  localparam int EAW = $clog2(ECHO_DEPTH);
  localparam int FAW = $clog2(FLANGE_DEPTH);

  localparam int CLEAR_LEN_PF = (PITCH_DEPTH > FLANGE_DEPTH) ? PITCH_DEPTH : FLANGE_DEPTH;
  localparam int CLEAR_LEN    = (ECHO_DEPTH > CLEAR_LEN_PF) ? ECHO_DEPTH : CLEAR_LEN_PF;
  localparam int CLEAR_W      = $clog2(CLEAR_LEN);

  localparam logic [0:0] REG_EFFECT_ENABLES = 1'b0;

  localparam int EN_UP      = 0;
  localparam int EN_DOWN    = 1;
  localparam int EN_CRUSH   = 2;
  localparam int EN_ECHO    = 3;
  localparam int EN_PHASOR  = 4;
  localparam int EN_LOWPASS = 5;

  localparam logic [SAMPLE_W-1:0] CRUSH_MASK = 8'hC0;

  localparam int LP_TAP_OUTER  = 22;
  localparam int LP_TAP_INNER  = 75;
  localparam int LP_TAP_CENTRE = 108;
  localparam int LP_HIST_LEN   = 6;
  localparam int LP_W          = 17;
  localparam int LP_SHIFT      = 8;

endpackage

@@ rtl/aec_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aec_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/audio_effect_chain_core.sv @@
// ----------------------------------------------------------------------------
// Audio effect chain core
// Pitch up, pitch down, bit crush, echo, phasor and low-pass on 8-bit samples.
// ----------------------------------------------------------------------------
// Samples enter on the in channel (in_valid, in_ready, sample_in) and leave on
// the out channel (out_valid, out_ready, sample_out), one result per item.
// The effects are switched on by the effect_enables register on the APB port;
// the user must write it only while no item is in flight, which the block does
// not enforce. The block takes one item per cycle while the skid register is
// empty and no clearing pass runs. Each delay effect owns one RAM, read one
// stage ahead of its write, with forwarding from the item just ahead and, in
// the two pitch effects, from the item's own write. After reset the block
// clears every delay RAM, one entry per cycle; in_ready stays low meanwhile.
// When the receiver stalls, the output register and a skid register hold up to
// two results; once the skid register fills, the pipeline and in_ready stop
// until the receiver takes a result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module audio_effect_chain_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [aec_pkg::SAMPLE_W-1:0]  sample_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [aec_pkg::SAMPLE_W-1:0]  sample_out,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [aec_pkg::ADDR_W-1:0]    paddr,
  input  logic [aec_pkg::DATA_W-1:0]    pwdata,
  output logic [aec_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  `include "audio_effect_chain_core_defines.svh"

  localparam int SW  = aec_pkg::SAMPLE_W;
  localparam int PAW = aec_pkg::PAW;
  localparam int EAW = aec_pkg::EAW;
  localparam int FAW = aec_pkg::FAW;
  localparam int CW  = aec_pkg::CLEAR_W;
  localparam int LW  = aec_pkg::LP_W;

  logic [aec_pkg::ENABLES_W-1:0] effect_enables;
  logic                          cfg_wr;

  logic          clr_busy;
  logic [CW-1:0] clr_idx;
  logic          clr_pitch;
  logic          clr_flange;

  logic adv;
  logic in_acc;

  logic v1, v2, v3, v4, v5;
  logic [SW-1:0] s1, s2, s3, s4, s5;

  logic [PAW-1:0] up_wr, up_rd, up_wr_next, up_rd_next;
  logic [PAW:0]   up_wr_sum, up_rd_sum;
  logic           up_issue, up_we, up_self1, up_fwd1;
  logic [PAW-1:0] up_wa1;
  logic [SW-1:0]  up_fwdd1, up_rdata, up_val;
  logic           up_ram_we;
  logic [PAW-1:0] up_ram_wa;
  logic [SW-1:0]  up_ram_wd;

  logic [PAW-1:0] dn_wr, dn_rd, dn_wr_next, dn_rd_next;
  logic [PAW:0]   dn_wr_sum, dn_rd_sum;
  logic           down_phase;
  logic           dn_issue, dn_we, dn_self2, dn_fwd2;
  logic [PAW-1:0] dn_wa2;
  logic [SW-1:0]  dn_fwdd2, dn_rdata, dn_val, crush_val;
  logic           dn_ram_we;
  logic [PAW-1:0] dn_ram_wa;
  logic [SW-1:0]  dn_ram_wd;

  logic [EAW-1:0] ec_wr, ec_rd, ec_wr_next, ec_rd_next;
  logic [EAW:0]   ec_wr_sum, ec_rd_sum;
  logic           echo_advance;
  logic           ec_issue, ec_we, ec_fwd3;
  logic [EAW-1:0] ec_wa3;
  logic [SW-1:0]  ec_fwdd3, ec_rdata, ec_dly, ec_sum, ec_val;
  logic           ec_ram_we;
  logic [EAW-1:0] ec_ram_wa;
  logic [SW-1:0]  ec_ram_wd;

  logic [FAW-1:0] fl_wr, fl_rd, fl_wr_next, fl_rd_next;
  logic [FAW:0]   fl_wr_sum, fl_rd_sum;
  logic           fl_issue, fl_we, fl_fwd4;
  logic [FAW-1:0] fl_wa4;
  logic [SW-1:0]  fl_fwdd4, fl_rdata, fl_dly, fl_mix, fl_val;
  logic           fl_ram_we;
  logic [FAW-1:0] fl_ram_wa;
  logic [SW-1:0]  fl_ram_wd;

  logic [SW-1:0]   lp_hist [aec_pkg::LP_HIST_LEN];
  logic [LW-1:0]   lp_acc;
  logic            lp_upd;
  logic [SW-1:0]   result;
  logic            push;

  logic          skid_valid;
  logic [SW-1:0] skid_data;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[aec_pkg::ADDR_W-1:2] == aec_pkg::REG_EFFECT_ENABLES);

  always_comb begin
    prdata = '0;
    if (paddr[aec_pkg::ADDR_W-1:2] == aec_pkg::REG_EFFECT_ENABLES) begin
      prdata = {{(aec_pkg::DATA_W-aec_pkg::ENABLES_W){1'b0}}, effect_enables};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      effect_enables <= '0;
    end else if (cfg_wr) begin
      effect_enables <= pwdata[aec_pkg::ENABLES_W-1:0];
    end
  end

  // Clearing pass over the delay RAMs after reset.
  assign clr_pitch  = ({1'b0, clr_idx} < (CW+1)'(aec_pkg::PITCH_DEPTH));
  assign clr_flange = ({1'b0, clr_idx} < (CW+1)'(aec_pkg::FLANGE_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_idx  <= '0;
    end else if (clr_busy) begin
      if (clr_idx == CW'(aec_pkg::CLEAR_LEN - 1)) begin
        clr_busy <= 1'b0;
      end
      clr_idx <= clr_idx + 1'b1;
    end
  end

  assign adv      = !skid_valid;
  assign in_ready = adv && !clr_busy;
  assign in_acc   = in_valid && in_ready;

  // Pitch up: read issued at acceptance, result and write in stage one.
  assign up_rd_sum  = {1'b0, up_rd} + (PAW+1)'(2);
  assign up_rd_next = (up_rd_sum >= (PAW+1)'(aec_pkg::PITCH_DEPTH - 1)) ? '0
                      : up_rd_sum[PAW-1:0];
  assign up_wr_sum  = {1'b0, up_wr} + (PAW+1)'(1);
  assign up_wr_next = (up_wr_sum >= (PAW+1)'(aec_pkg::PITCH_DEPTH - 1)) ? '0
                      : up_wr_sum[PAW-1:0];
  assign up_issue   = in_acc && effect_enables[aec_pkg::EN_UP];
  assign up_we      = adv && v1 && effect_enables[aec_pkg::EN_UP];

  always_comb begin
    up_val = up_rdata;
    if (!effect_enables[aec_pkg::EN_UP] || up_self1) begin
      up_val = s1;
    end else if (up_fwd1) begin
      up_val = up_fwdd1;
    end
  end

  assign up_ram_we = clr_busy ? clr_pitch : up_we;
  assign up_ram_wa = clr_busy ? clr_idx[PAW-1:0] : up_wa1;
  assign up_ram_wd = clr_busy ? '0 : s1;

  aec_ram #(.WIDTH(SW), .DEPTH(aec_pkg::PITCH_DEPTH)) u_up_ram (
    .clk   (clk),
    .we    (up_ram_we),
    .waddr (up_ram_wa),
    .wdata (up_ram_wd),
    .re    (adv),
    .raddr (up_rd_next),
    .rdata (up_rdata)
  );

  // Pitch down: read issued in stage one, result and write in stage two.
  assign dn_rd_sum  = {1'b0, dn_rd} + (PAW+1)'(down_phase);
  assign dn_rd_next = (dn_rd_sum >= (PAW+1)'(aec_pkg::PITCH_DEPTH - 1)) ? '0
                      : dn_rd_sum[PAW-1:0];
  assign dn_wr_sum  = {1'b0, dn_wr} + (PAW+1)'(1);
  assign dn_wr_next = (dn_wr_sum >= (PAW+1)'(aec_pkg::PITCH_DEPTH - 1)) ? '0
                      : dn_wr_sum[PAW-1:0];
  assign dn_issue   = adv && v1 && effect_enables[aec_pkg::EN_DOWN];
  assign dn_we      = adv && v2 && effect_enables[aec_pkg::EN_DOWN];

  always_comb begin
    dn_val = dn_rdata;
    if (!effect_enables[aec_pkg::EN_DOWN] || dn_self2) begin
      dn_val = s2;
    end else if (dn_fwd2) begin
      dn_val = dn_fwdd2;
    end
  end

  assign crush_val = effect_enables[aec_pkg::EN_CRUSH] ? (dn_val & aec_pkg::CRUSH_MASK)
                     : dn_val;

  assign dn_ram_we = clr_busy ? clr_pitch : dn_we;
  assign dn_ram_wa = clr_busy ? clr_idx[PAW-1:0] : dn_wa2;
  assign dn_ram_wd = clr_busy ? '0 : s2;

  aec_ram #(.WIDTH(SW), .DEPTH(aec_pkg::PITCH_DEPTH)) u_down_ram (
    .clk   (clk),
    .we    (dn_ram_we),
    .waddr (dn_ram_wa),
    .wdata (dn_ram_wd),
    .re    (adv),
    .raddr (dn_rd_next),
    .rdata (dn_rdata)
  );

  // Echo: read issued in stage two, result and write in stage three.
  assign ec_rd_sum  = {1'b0, ec_rd} + (EAW+1)'(1);
  assign ec_rd_next = (ec_rd_sum >= (EAW+1)'(aec_pkg::ECHO_DEPTH - 1)) ? '0
                      : ec_rd_sum[EAW-1:0];
  assign ec_wr_sum  = {1'b0, ec_wr} + (EAW+1)'(1);
  assign ec_wr_next = (ec_wr_sum >= (EAW+1)'(aec_pkg::ECHO_DEPTH - 1)) ? '0
                      : ec_wr_sum[EAW-1:0];
  assign ec_issue   = adv && v2 && effect_enables[aec_pkg::EN_ECHO];
  assign ec_we      = adv && v3 && effect_enables[aec_pkg::EN_ECHO];
  assign ec_dly     = ec_fwd3 ? ec_fwdd3 : ec_rdata;
  assign ec_sum     = s3 + (ec_dly >> 1);
  assign ec_val     = effect_enables[aec_pkg::EN_ECHO] ? ec_sum : s3;

  assign ec_ram_we = clr_busy ? 1'b1 : ec_we;
  assign ec_ram_wa = clr_busy ? clr_idx[EAW-1:0] : ec_wa3;
  assign ec_ram_wd = clr_busy ? '0 : ec_sum;

  aec_ram #(.WIDTH(SW), .DEPTH(aec_pkg::ECHO_DEPTH)) u_echo_ram (
    .clk   (clk),
    .we    (ec_ram_we),
    .waddr (ec_ram_wa),
    .wdata (ec_ram_wd),
    .re    (adv),
    .raddr (ec_rd),
    .rdata (ec_rdata)
  );

  // Phasor: read issued in stage three, result and write in stage four.
  assign fl_rd_sum  = {1'b0, fl_rd} + (FAW+1)'(1);
  assign fl_rd_next = (fl_rd_sum >= (FAW+1)'(aec_pkg::FLANGE_DEPTH - 1)) ? '0
                      : fl_rd_sum[FAW-1:0];
  assign fl_wr_sum  = {1'b0, fl_wr} + (FAW+1)'(1);
  assign fl_wr_next = (fl_wr_sum >= (FAW+1)'(aec_pkg::FLANGE_DEPTH)) ? '0
                      : fl_wr_sum[FAW-1:0];
  assign fl_issue   = adv && v3 && effect_enables[aec_pkg::EN_PHASOR];
  assign fl_we      = adv && v4 && effect_enables[aec_pkg::EN_PHASOR];
  assign fl_dly     = fl_fwd4 ? fl_fwdd4 : fl_rdata;
  assign fl_mix     = (s4 >> 1) + (fl_dly >> 1);
  assign fl_val     = effect_enables[aec_pkg::EN_PHASOR] ? fl_mix : s4;

  assign fl_ram_we = clr_busy ? clr_flange : fl_we;
  assign fl_ram_wa = clr_busy ? clr_idx[FAW-1:0] : fl_wa4;
  assign fl_ram_wd = clr_busy ? '0 : s4;

  aec_ram #(.WIDTH(SW), .DEPTH(aec_pkg::FLANGE_DEPTH)) u_flange_ram (
    .clk   (clk),
    .we    (fl_ram_we),
    .waddr (fl_ram_wa),
    .wdata (fl_ram_wd),
    .re    (adv),
    .raddr (fl_rd),
    .rdata (fl_rdata)
  );

  // Low-pass on stage five, from the history before this item is shifted in.
  assign lp_acc =
      LW'(aec_pkg::LP_TAP_OUTER)  * LW'(lp_hist[1]) +
      LW'(aec_pkg::LP_TAP_INNER)  * LW'(lp_hist[2]) +
      LW'(aec_pkg::LP_TAP_CENTRE) * LW'(lp_hist[3]) +
      LW'(aec_pkg::LP_TAP_INNER)  * LW'(lp_hist[4]) +
      LW'(aec_pkg::LP_TAP_OUTER)  * LW'(lp_hist[5]);
  assign lp_upd = adv && v5 && effect_enables[aec_pkg::EN_LOWPASS];
  assign result = effect_enables[aec_pkg::EN_LOWPASS] ? lp_acc[aec_pkg::LP_SHIFT +: SW]
                  : s5;
  assign push   = adv && v5;

  // Pointer and history state.
  always_ff @(posedge clk) begin
    if (rst) begin
      up_wr        <= '0;
      up_rd        <= PAW'(1);
      dn_wr        <= '0;
      dn_rd        <= PAW'(1);
      down_phase   <= 1'b0;
      ec_wr        <= '0;
      ec_rd        <= EAW'(1);
      echo_advance <= 1'b1;
      fl_wr        <= '0;
      fl_rd        <= FAW'(1);
      for (int i = 0; i < aec_pkg::LP_HIST_LEN; i++) begin
        lp_hist[i] <= '0;
      end
    end else begin
      if (up_issue) begin
        up_wr <= up_wr_next;
        up_rd <= up_rd_next;
      end
      if (dn_issue) begin
        dn_wr      <= dn_wr_next;
        dn_rd      <= dn_rd_next;
        down_phase <= !down_phase;
      end
      if (ec_issue) begin
        if (echo_advance) begin
          ec_wr <= ec_wr_next;
          ec_rd <= ec_rd_next;
        end
        echo_advance <= !echo_advance;
      end
      if (fl_issue) begin
        fl_wr <= fl_wr_next;
        fl_rd <= fl_rd_next;
      end
      if (lp_upd) begin
        lp_hist[0] <= s5;
        for (int i = 1; i < aec_pkg::LP_HIST_LEN; i++) begin
          lp_hist[i] <= lp_hist[i-1];
        end
      end
    end
  end

  // Pipeline valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (adv) begin
      v1 <= in_acc;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  // Pipeline payload, write addresses and forwarding flags.
  always_ff @(posedge clk) begin
    if (adv) begin
      s1       <= sample_in;
      up_wa1   <= up_wr;
      up_self1 <= (up_rd_next == up_wr);
      up_fwd1  <= up_we && (up_rd_next == up_wa1);
      up_fwdd1 <= s1;

      s2       <= up_val;
      dn_wa2   <= dn_wr;
      dn_self2 <= (dn_rd_next == dn_wr);
      dn_fwd2  <= dn_we && (dn_rd_next == dn_wa2);
      dn_fwdd2 <= s2;

      s3       <= crush_val;
      ec_wa3   <= ec_wr;
      ec_fwd3  <= ec_we && (ec_rd == ec_wa3);
      ec_fwdd3 <= ec_sum;

      s4       <= ec_val;
      fl_wa4   <= fl_wr;
      fl_fwd4  <= fl_we && (fl_rd == fl_wa4);
      fl_fwdd4 <= s4;

      s5       <= fl_val;
    end
  end

  // Output register with a skid register behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !out_ready) begin
      if (push) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && !out_ready) begin
      if (push) begin
        skid_data <= result;
      end
    end else if (skid_valid) begin
      sample_out <= skid_data;
    end else if (push) begin
      sample_out <= result;
    end
  end

  `AEC_ASSERT_IMP(a_clear_blocks_input, clr_busy, !in_ready,
                  "Input accepted during the RAM clearing pass")
  `AEC_ASSERT_IMP(a_skid_behind_output, skid_valid, out_valid,
                  "Skid register holds an item while the output register is empty")
  `AEC_ASSERT_IMP(a_skid_fill_on_stall, $rose(skid_valid), $past(out_valid && !out_ready),
                  "Skid register filled without an output stall")
  `AEC_ASSERT_NXT(a_echo_rate_toggle, ec_issue, echo_advance != $past(echo_advance),
                  "Echo update phase did not toggle")

endmodule

@@ sim/aec_chain_checker.sv @@
// ----------------------------------------------------------------------------
// Audio effect chain checker
// Watches the sample channels and the register port of the effect chain,
// keeps its own copy of every effect's state, predicts the processed sample
// for each accepted item and compares it with the sample that leaves.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aec_chain_checker
  import aec_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [SAMPLE_W-1:0] sample_in,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [SAMPLE_W-1:0] sample_out,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  input  logic                pready,
  output int                  mismatches,
  output int                  pending
);

  logic [ENABLES_W-1:0] enables;

  logic [SAMPLE_W-1:0] up_mem     [PITCH_DEPTH];
  logic [SAMPLE_W-1:0] down_mem   [PITCH_DEPTH];
  logic [SAMPLE_W-1:0] echo_mem   [ECHO_DEPTH];
  logic [SAMPLE_W-1:0] flange_mem [FLANGE_DEPTH];
  logic [SAMPLE_W-1:0] lp_hist    [8];

  int unsigned up_wr, up_rd;
  int unsigned down_wr, down_rd;
  bit          down_phase;
  int unsigned echo_wr, echo_rd;
  bit          echo_advance;
  int unsigned flange_wr, flange_rd;

  logic [SAMPLE_W-1:0] expected_out [$];
  int                  error_total = 0;

  function automatic logic [SAMPLE_W-1:0] run_chain(input logic [SAMPLE_W-1:0] x);
    logic [SAMPLE_W-1:0] s;
    logic [SAMPLE_W-1:0] mix;
    int unsigned         acc;
    s = x;
    if (enables[EN_UP]) begin
      up_mem[up_wr] = s;
      up_rd = up_rd + 2;
      if (up_rd >= PITCH_DEPTH - 1) up_rd = 0;
      up_wr = up_wr + 1;
      if (up_wr >= PITCH_DEPTH - 1) up_wr = 0;
      s = up_mem[up_rd];
    end
    if (enables[EN_DOWN]) begin
      down_mem[down_wr] = s;
      if (down_phase) begin
        down_rd = down_rd + 1;
        down_phase = 1'b0;
      end else begin
        down_phase = 1'b1;
      end
      if (down_rd >= PITCH_DEPTH - 1) down_rd = 0;
      down_wr = down_wr + 1;
      if (down_wr >= PITCH_DEPTH - 1) down_wr = 0;
      s = down_mem[down_rd];
    end
    if (enables[EN_CRUSH]) begin
      s = s & CRUSH_MASK;
    end
    if (enables[EN_ECHO]) begin
      s = s + (echo_mem[echo_rd] >> 1);
      echo_mem[echo_wr] = s;
      if (echo_advance) begin
        echo_rd = echo_rd + 1;
        if (echo_rd >= ECHO_DEPTH - 1) echo_rd = 0;
        echo_wr = echo_wr + 1;
        if (echo_wr >= ECHO_DEPTH - 1) echo_wr = 0;
        echo_advance = 1'b0;
      end else begin
        echo_advance = 1'b1;
      end
    end
    if (enables[EN_PHASOR]) begin
      mix = (s >> 1) + (flange_mem[flange_rd] >> 1);
      flange_mem[flange_wr] = s;
      flange_rd = flange_rd + 1;
      if (flange_rd >= FLANGE_DEPTH - 1) flange_rd = 0;
      flange_wr = flange_wr + 1;
      if (flange_wr >= FLANGE_DEPTH) flange_wr = 0;
      s = mix;
    end
    if (enables[EN_LOWPASS]) begin
      for (int k = 7; k > 0; k--) lp_hist[k] = lp_hist[k-1];
      lp_hist[0] = s;
      acc = LP_TAP_OUTER * lp_hist[2] + LP_TAP_INNER * lp_hist[3]
          + LP_TAP_CENTRE * lp_hist[4] + LP_TAP_INNER * lp_hist[5]
          + LP_TAP_OUTER * lp_hist[6];
      s = SAMPLE_W'(acc >> LP_SHIFT);
    end
    return s;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      enables = '0;
      for (int i = 0; i < PITCH_DEPTH; i++) begin
        up_mem[i]   = '0;
        down_mem[i] = '0;
      end
      for (int i = 0; i < ECHO_DEPTH; i++) echo_mem[i] = '0;
      for (int i = 0; i < FLANGE_DEPTH; i++) flange_mem[i] = '0;
      for (int i = 0; i < 8; i++) lp_hist[i] = '0;
      up_wr = 0;     up_rd = 1;
      down_wr = 0;   down_rd = 1;   down_phase = 1'b0;
      echo_wr = 0;   echo_rd = 1;   echo_advance = 1'b1;
      flange_wr = 0; flange_rd = 1;
      expected_out.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00
          && paddr[ADDR_W-1:2] == REG_EFFECT_ENABLES) begin
        enables = pwdata[ENABLES_W-1:0];
      end
      if (out_valid && out_ready) begin
        if (expected_out.size() == 0) begin
          $error("sample_out: no item expected, actual %0d", sample_out);
          error_total++;
        end else if (sample_out !== expected_out[0]) begin
          $error("sample_out: expected %0d, actual %0d", expected_out[0], sample_out);
          error_total++;
          void'(expected_out.pop_front());
        end else begin
          void'(expected_out.pop_front());
        end
      end
      if (in_valid && in_ready) begin
        expected_out.push_back(run_chain(sample_in));
      end
    end
    mismatches <= error_total;
    pending    <= expected_out.size();
  end

endmodule

@@ sim/tb_audio_effect_chain_core.sv @@
// ----------------------------------------------------------------------------
// Audio effect chain testbench
// Drives samples and effect settings into the chain with random gaps on both
// channels, leaves prediction and comparison to the checker, and reports the
// outcome once every expected sample has come out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_audio_effect_chain_core;
  import aec_pkg::*;

  localparam int RANDOM_ITEMS = 1450;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam logic [ADDR_W-3:0] UNMAPPED_REG = 1'b1;

  logic                clk = 1'b0;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic [SAMPLE_W-1:0] sample_in;
  logic                out_valid;
  logic                out_ready;
  logic [SAMPLE_W-1:0] sample_out;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  int mismatches;
  int pending;
  int cycle_count = 0;
  bit calm = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  audio_effect_chain_core DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sample_in  (sample_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  aec_chain_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sample_in  (sample_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_audio_effect_chain_core: done, errors");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  initial begin
    int stall;
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      stall = calm ? 0 : pick_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(negedge clk);
    end
  end

  task automatic send_sample(input logic [SAMPLE_W-1:0] value);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    sample_in <= value;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic drain_chain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic reg_write(input logic [ADDR_W-3:0] index, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    logic [ENABLES_W-1:0] fx;
    logic [ENABLES_W-1:0] sweep [8];
    logic [DATA_W-1:0]    word;
    logic [SAMPLE_W-1:0]  value;
    logic [SAMPLE_W-1:0]  ramp;
    logic [SAMPLE_W-1:0]  step;
    int                   sent;
    int                   phase;
    int                   count;
    int                   style;

    rst       = 1'b1;
    in_valid  = 1'b0;
    sample_in = '0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Everything bypassed after reset.
    send_sample(8'h00);
    send_sample(8'hFF);
    send_sample(8'h55);
    send_sample(8'hAA);
    drain_chain();

    // All effects on; the upper bits of the written word must be dropped.
    reg_write(REG_EFFECT_ENABLES, '1);
    send_sample(8'h00);
    send_sample(8'hFF);
    send_sample(8'h80);
    send_sample(8'h7F);
    send_sample(8'h01);
    send_sample(8'hFE);
    drain_chain();

    // A write to an unmapped register must leave the settings alone.
    reg_write(UNMAPPED_REG, '0);
    send_sample(8'h33);
    send_sample(8'hCC);
    drain_chain();

    // A run of full-scale items drives the low-pass sum to its peak, which fits without wrapping.
    reg_write(REG_EFFECT_ENABLES, DATA_W'(1 << EN_LOWPASS));
    repeat (7) send_sample(8'hFF);
    send_sample(8'h00);
    drain_chain();

    reg_write(REG_EFFECT_ENABLES, DATA_W'(1 << EN_CRUSH));
    send_sample(8'hFF);
    send_sample(8'h3F);
    send_sample(8'hC0);
    drain_chain();

    sweep[0] = '0;
    sweep[1] = '1;
    sweep[2] = ENABLES_W'(1 << EN_UP);
    sweep[3] = ENABLES_W'(1 << EN_DOWN);
    sweep[4] = ENABLES_W'(1 << EN_CRUSH);
    sweep[5] = ENABLES_W'(1 << EN_ECHO);
    sweep[6] = ENABLES_W'(1 << EN_PHASOR);
    sweep[7] = ENABLES_W'(1 << EN_LOWPASS);

    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      if (phase < 8) begin
        fx = sweep[phase];
      end else begin
        fx = ENABLES_W'($urandom_range(0, 63));
        if ($urandom_range(0, 4) != 0) fx[EN_ECHO] = 1'b1;
      end
      if ($urandom_range(0, 5) == 0) reg_write(UNMAPPED_REG, $urandom);
      word = $urandom;
      reg_write(REG_EFFECT_ENABLES, {word[DATA_W-1:ENABLES_W], fx});
      calm  = (phase % 4 == 3);
      count = $urandom_range(30, 110);
      style = $urandom_range(0, 3);
      ramp  = SAMPLE_W'($urandom);
      step  = SAMPLE_W'($urandom_range(1, 9));
      for (int i = 0; i < count; i++) begin
        case (style)
          0: begin
            value = SAMPLE_W'($urandom_range(0, 255));
          end
          1: begin
            case ($urandom_range(0, 4))
              0: value = 8'h00;
              1: value = 8'hFF;
              2: value = 8'h80;
              3: value = 8'h7F;
              default: value = SAMPLE_W'($urandom_range(0, 255));
            endcase
          end
          2: begin
            ramp  = ramp + step;
            value = ramp;
          end
          default: begin
            value = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : 8'hFF;
          end
        endcase
        send_sample(value);
      end
      drain_chain();
      sent  = sent + count;
      phase = phase + 1;
    end

    calm = 1'b0;
    repeat (20) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("tb_audio_effect_chain_core: done, clean");
    end else begin
      $display("tb_audio_effect_chain_core: done, errors");
    end
    $finish;
  end

endmodule
